/* hdl/crt_pkg.sv */
// Package: shared types and constants for the checkpoint revision tracker.
package crt_pkg;

    localparam int ID_SLOTS_DEF   = 1024;
    localparam int COMPONENTS_DEF = 14;
    localparam int REV_BITS_DEF   = 32;
    localparam int IDENT_W        = 10;
    localparam int MASK_W         = 14;
    localparam int CNT_W          = 11;
    localparam int ACT_W          = 4;
    localparam int IN_REV_W       = 32;

    localparam logic [ACT_W-1:0] ACT_HYDRATE  = 4'd0;
    localparam logic [ACT_W-1:0] ACT_MARK     = 4'd1;
    localparam logic [ACT_W-1:0] ACT_QUEUE    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_BEGIN    = 4'd3;
    localparam logic [ACT_W-1:0] ACT_ACK      = 4'd4;
    localparam logic [ACT_W-1:0] ACT_ACK_DUR  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_FAIL     = 4'd6;
    localparam logic [ACT_W-1:0] ACT_SNAPSHOT = 4'd7;
    localparam logic [ACT_W-1:0] ACT_FORGET   = 4'd8;

    localparam logic CFG_IDX_MASK = 1'b0;
    localparam logic CFG_IDX_CAP  = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_OUT   = 4'b0100,
        ST_CLEAR = 4'b1000
    } state_t;

endpackage

/* hdl/crt_store.sv */
// Record memory: valid bits, header fields and per-component revisions, registered read.
module crt_store #(
    parameter int ID_SLOTS   = crt_pkg::ID_SLOTS_DEF,
    parameter int COMPONENTS = crt_pkg::COMPONENTS_DEF,
    parameter int REV_BITS   = crt_pkg::REV_BITS_DEF,
    parameter int AW         = $clog2(ID_SLOTS),
    parameter int HW         = 4 * REV_BITS + 4 * COMPONENTS + 1
) (
    input  logic                           aclk,
    input  logic [AW-1:0]                  rd_addr,
    output logic                           rd_vld,
    output logic [HW-1:0]                  rd_hdr,
    output logic [COMPONENTS*REV_BITS-1:0] rd_crev,
    input  logic                           wr_en,
    input  logic                           vld_wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic                           wr_vld,
    input  logic [HW-1:0]                  wr_hdr,
    input  logic [COMPONENTS*REV_BITS-1:0] wr_crev
);
    logic                           vld_mem  [ID_SLOTS];
    logic [HW-1:0]                  hdr_mem  [ID_SLOTS];
    logic [COMPONENTS*REV_BITS-1:0] crev_mem [ID_SLOTS];

    // Valid bit per slot
    always_ff @(posedge aclk) begin
        if (vld_wr_en) begin
            vld_mem[wr_addr] <= wr_vld;
        end
        rd_vld <= vld_mem[rd_addr];
    end

    // Header row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hdr_mem[wr_addr] <= wr_hdr;
        end
        rd_hdr <= hdr_mem[rd_addr];
    end

    // Component revision row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            crev_mem[wr_addr] <= wr_crev;
        end
        rd_crev <= crev_mem[rd_addr];
    end
endmodule

/* hdl/checkpoint_revision_tracker_top.sv */
// Top level of the checkpoint revision tracker.
// Each request is a read-modify-write of one record held in on-chip memory:
// the idle state accepts the request and starts the memory read, the read
// state computes and writes back, and the output state holds the result in
// an output register until it is taken; the next request is accepted in the
// cycle after the result is taken, so a new request is never accepted while
// one is still in progress. Validity lives in a memory of one bit per slot;
// after reset a clearing pass over all ID_SLOTS slots (1024 by default)
// zeroes it while the input is held off. Configuration is taken at any time.
module checkpoint_revision_tracker_top #(
    parameter int ID_SLOTS   = crt_pkg::ID_SLOTS_DEF,
    parameter int COMPONENTS = crt_pkg::COMPONENTS_DEF,
    parameter int REV_BITS   = crt_pkg::REV_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // cfg_data: register value
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    // s_axis_tdata: action[3:0], ident[13:4], rev_in[45:14], mask_in[59:46]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,
    // m_axis_tdata: ok[0], cur_rev[32:1], acked_rev[64:33], queued_rev[96:65],
    // flight_rev[128:97], dirty_mask[142:129], unacked_mask[156:143],
    // queued_mask[170:157], flight_mask[184:171], overflow_flag[185],
    // entries_used[196:186], entries_unacked[207:197]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [207:0] m_axis_tdata
);
    localparam int AW = $clog2(ID_SLOTS);
    localparam int RB = REV_BITS;
    localparam int NC = COMPONENTS;
    localparam int MW = crt_pkg::MASK_W;
    localparam int CW = crt_pkg::CNT_W;
    localparam int HW = 4 * RB + 4 * NC + 1;
    localparam logic [RB-1:0] REV_MAX = {RB{1'b1}};

    // Configuration registers
    logic [MW-1:0] all_mask_reg;
    logic [CW-1:0] cap_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            all_mask_reg <= {MW{1'b1}};
            cap_reg      <= CW'(1024);
        end else if (cfg_valid) begin
            if (cfg_index == crt_pkg::CFG_IDX_MASK) begin
                all_mask_reg <= cfg_data[MW-1:0];
            end else begin
                cap_reg <= cfg_data[CW-1:0];
            end
        end
    end

    // Request capture
    crt_pkg::state_t state_reg, state_next;
    logic [3:0]    act_reg;
    logic [9:0]    ident_reg;
    logic [31:0]   rev_in_reg;
    logic [MW-1:0] mask_in_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clr_last;
    logic [CW-1:0] used_reg, used_next, unacked_reg, unacked_next;
    logic [207:0]  out_reg, out_next;

    assign s_axis_tready = (state_reg == crt_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == crt_pkg::ST_OUT);
    assign m_axis_tdata  = out_reg;
    assign clr_last      = (clr_addr_reg == AW'(ID_SLOTS - 1));

    logic s_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg     <= s_axis_tdata[3:0];
            ident_reg   <= s_axis_tdata[13:4];
            rev_in_reg  <= s_axis_tdata[45:14];
            mask_in_reg <= s_axis_tdata[59:46];
        end
    end

    // Memory
    logic [HW-1:0]    rd_hdr, wr_hdr;
    logic [NC*RB-1:0] rd_crev, wr_crev;
    logic             wr_en, vld_wr_en, wr_vld, rd_vld;
    logic [AW-1:0]    s_addr, addr, mem_wr_addr;
    assign s_addr = AW'(s_axis_tdata[13:4]);
    assign addr   = AW'(ident_reg);

    crt_store #(.ID_SLOTS(ID_SLOTS), .COMPONENTS(NC), .REV_BITS(RB)) u_store (
        .aclk(aclk), .rd_addr(s_addr), .rd_vld(rd_vld), .rd_hdr(rd_hdr),
        .rd_crev(rd_crev), .wr_en(wr_en), .vld_wr_en(vld_wr_en),
        .wr_addr(mem_wr_addr), .wr_vld(wr_vld), .wr_hdr(wr_hdr), .wr_crev(wr_crev)
    );

    // Unpack record
    logic [RB-1:0] cur, ack, qrev, frev;
    logic [NC-1:0] dirty, unack, qm, fm;
    logic          ovf;
    assign {ovf, fm, qm, unack, dirty, frev, qrev, ack, cur} = rd_hdr;

    // Compute
    logic          inrange, v, v_after, ok;
    logic [RB-1:0] rev, n_cur, n_ack, n_qrev, n_frev;
    logic [NC-1:0] n_dirty, n_unack, n_qm, n_fm, m, legal_bits, clr;
    logic          n_ovf, legal, pend;
    logic [NC*RB-1:0] n_crev;
    logic [MW-1:0] mask_ext;

    always_comb begin
        inrange = (ident_reg != 10'd0) && (32'(ident_reg) < 32'(ID_SLOTS));
        v       = inrange && rd_vld;
        rev     = RB'(rev_in_reg);
        m       = NC'(mask_in_reg);
        legal_bits = NC'(all_mask_reg);
        mask_ext = MW'(m);
        legal   = (m != '0) && ((m & ~legal_bits) == '0) && (mask_ext == mask_in_reg);
        pend    = (unack != '0) || (qm != '0) || (fm != '0);
        for (int i = 0; i < NC; i++) begin
            clr[i] = m[i] && (rd_crev[i*RB +: RB] <= rev);
        end
        n_cur = cur; n_ack = ack; n_qrev = qrev; n_frev = frev;
        n_dirty = dirty; n_unack = unack; n_qm = qm; n_fm = fm; n_ovf = ovf;
        n_crev = rd_crev;
        ok = 1'b0;
        v_after = v;
        used_next = used_reg;
        if (inrange) begin
            case (act_reg)
                crt_pkg::ACT_HYDRATE: begin
                    if (v) begin
                        if (pend) begin
                            ok = (rev == ack);
                        end else if (rev >= ack) begin
                            n_cur = rev; n_ack = rev;
                            n_crev = {NC{rev}};
                            ok = 1'b1;
                        end
                    end else if (used_reg < cap_reg) begin
                        v_after = 1'b1;
                        used_next = used_reg + 1'b1;
                        n_cur = rev; n_ack = rev; n_crev = {NC{rev}};
                        n_qrev = '0; n_frev = '0; n_dirty = '0; n_unack = '0;
                        n_qm = '0; n_fm = '0; n_ovf = 1'b0;
                        ok = 1'b1;
                    end
                end
                crt_pkg::ACT_MARK: begin
                    if (v && legal && !ovf) begin
                        if (cur == REV_MAX) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_cur = cur + 1'b1;
                            n_dirty = dirty | m;
                            n_unack = unack | m;
                            for (int i = 0; i < NC; i++) begin
                                if (m[i]) n_crev[i*RB +: RB] = n_cur;
                            end
                            ok = 1'b1;
                        end
                    end
                end
                crt_pkg::ACT_QUEUE: begin
                    if (v && unack != '0) begin
                        n_qrev = cur; n_qm = unack; n_dirty = '0; ok = 1'b1;
                    end
                end
                crt_pkg::ACT_BEGIN: begin
                    if (v && fm == '0 && rev == qrev && m == qm && legal) begin
                        n_frev = rev; n_fm = m; n_qrev = '0; n_qm = '0; ok = 1'b1;
                    end
                end
                crt_pkg::ACT_ACK: begin
                    if (v && rev == frev && m == fm && legal) begin
                        n_unack = unack & ~clr; n_dirty = dirty & ~clr;
                        n_qm = qm & ~clr;
                        if (rev > ack) n_ack = rev;
                        n_frev = '0; n_fm = '0; ok = 1'b1;
                    end
                end
                crt_pkg::ACT_ACK_DUR: begin
                    if (v && legal && rev >= ack && rev <= cur) begin
                        n_unack = unack & ~clr; n_dirty = dirty & ~clr;
                        n_qm = qm & ~clr;
                        n_fm = fm & ~(unack & clr);
                        if (n_qm == '0) n_qrev = '0;
                        if (n_fm == '0) n_frev = '0;
                        if (rev > ack) n_ack = rev;
                        ok = 1'b1;
                    end
                end
                crt_pkg::ACT_FAIL: begin
                    if (v && rev == frev && m == fm && legal) begin
                        n_frev = '0; n_fm = '0; n_qrev = cur; n_qm = unack; ok = 1'b1;
                    end
                end
                crt_pkg::ACT_SNAPSHOT: ok = v;
                crt_pkg::ACT_FORGET: begin
                    if (v) begin
                        v_after = 1'b0; used_next = used_reg - 1'b1; ok = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        // Write back; the clearing pass owns the valid memory after reset
        wr_en = (state_reg == crt_pkg::ST_READ) && v_after;
        vld_wr_en = (state_reg == crt_pkg::ST_CLEAR) ||
                    ((state_reg == crt_pkg::ST_READ) && inrange);
        wr_vld = (state_reg == crt_pkg::ST_READ) && v_after;
        mem_wr_addr = (state_reg == crt_pkg::ST_CLEAR) ? clr_addr_reg : addr;
        wr_hdr = {n_ovf, n_fm, n_qm, n_unack, n_dirty, n_frev, n_qrev, n_ack, n_cur};
        wr_crev = n_crev;
        unacked_next = unacked_reg - CW'(v && unack != '0)
                       + CW'(v_after && n_unack != '0);
        out_next = '0;
        out_next[0] = ok;
        if (v_after) begin
            out_next[32:1]    = 32'(n_cur);
            out_next[64:33]   = 32'(n_ack);
            out_next[96:65]   = 32'(n_qrev);
            out_next[128:97]  = 32'(n_frev);
            out_next[142:129] = MW'(n_dirty);
            out_next[156:143] = MW'(n_unack);
            out_next[170:157] = MW'(n_qm);
            out_next[184:171] = MW'(n_fm);
            out_next[185]     = n_ovf;
        end
        out_next[196:186] = used_next;
        out_next[207:197] = unacked_next;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crt_pkg::ST_CLEAR: if (clr_last) state_next = crt_pkg::ST_IDLE;
            crt_pkg::ST_IDLE:  if (s_fire) state_next = crt_pkg::ST_READ;
            crt_pkg::ST_READ:  state_next = crt_pkg::ST_OUT;
            crt_pkg::ST_OUT:   if (m_axis_tready) state_next = crt_pkg::ST_IDLE;
            default:           state_next = crt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= crt_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            used_reg     <= '0;
            unacked_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == crt_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (state_reg == crt_pkg::ST_READ) begin
                used_reg    <= used_next;
                unacked_reg <= unacked_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == crt_pkg::ST_READ) begin
            out_reg <= out_next;
        end
    end
endmodule

/* verif/tb.sv */
// Testbench for the checkpoint revision tracker: directed and random actions checked by a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int NSLOT   = 1024;
    localparam int NCOMP   = 14;
    localparam int IDLE_TO = 20000;

    // result layout, lowest field last
    typedef struct packed {
        logic [10:0] entries_unacked;
        logic [10:0] entries_used;
        logic        overflow_flag;
        logic [13:0] flight_mask;
        logic [13:0] queued_mask;
        logic [13:0] unacked_mask;
        logic [13:0] dirty_mask;
        logic [31:0] flight_rev;
        logic [31:0] queued_rev;
        logic [31:0] acked_rev;
        logic [31:0] cur_rev;
        logic        ok;
    } record_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = crt_pkg::CFG_IDX_MASK;
    logic [15:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [207:0] m_axis_tdata;

    checkpoint_revision_tracker_top i_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor copy of the record table
    logic [13:0] comp_mask_cfg = 14'h3FFF;
    logic [10:0] cap_cfg = 11'd1024;
    logic        rec_valid [NSLOT];
    logic [31:0] rec_cur [NSLOT];
    logic [31:0] rec_acked [NSLOT];
    logic [31:0] rec_qrev [NSLOT];
    logic [31:0] rec_frev [NSLOT];
    logic [13:0] rec_dirty [NSLOT];
    logic [13:0] rec_unack [NSLOT];
    logic [13:0] rec_qmask [NSLOT];
    logic [13:0] rec_fmask [NSLOT];
    logic        rec_ovf [NSLOT];
    logic [31:0] rec_comp_rev [NSLOT][NCOMP];
    logic [10:0] used_cnt = '0;
    logic [10:0] unacked_cnt = '0;

    record_res_t pending_results[$];
    int          mismatches = 0;
    bit          tx_nogap = 0;
    bit          rx_nogap = 0;
    int          rx_hold_len = 0;
    int          idle_cycles = 0;

    // empty table; stimulus may read fields of records never hydrated
    initial begin
        foreach (rec_valid[i]) begin
            rec_valid[i] = 1'b0;
            rec_cur[i] = '0;
            rec_acked[i] = '0;
            rec_qrev[i] = '0;
            rec_frev[i] = '0;
            rec_dirty[i] = '0;
            rec_unack[i] = '0;
            rec_qmask[i] = '0;
            rec_fmask[i] = '0;
            rec_ovf[i] = 1'b0;
            for (int j = 0; j < NCOMP; j++) rec_comp_rev[i][j] = '0;
        end
    end

    function automatic bit mask_legal(logic [13:0] m);
        return m != 0 && (m & ~comp_mask_cfg) == 0;
    endfunction

    // drop components of m whose revision is at or below rev
    task automatic retire_components(int s, logic [31:0] rev, logic [13:0] m);
        for (int i = 0; i < NCOMP; i++) begin
            if (m[i] && rec_comp_rev[s][i] <= rev) begin
                rec_unack[s][i] = 1'b0;
                rec_dirty[s][i] = 1'b0;
                rec_qmask[s][i] = 1'b0;
            end
        end
    endtask

    task automatic load_record(int s, logic [31:0] rev);
        rec_cur[s] = rev;
        rec_acked[s] = rev;
        for (int i = 0; i < NCOMP; i++) rec_comp_rev[s][i] = rev;
    endtask

    task automatic apply_action(logic [3:0] act, logic [9:0] id, logic [31:0] rev,
                                logic [13:0] m);
        record_res_t r;
        bit          ok;
        bit          v;
        int          s;
        logic [13:0] prior_unack;
        ok = 0;
        s = id;
        v = (id != 0) && rec_valid[s];
        if (v && rec_unack[s] != 0) unacked_cnt--;
        if (id != 0) begin
            case (act)
                crt_pkg::ACT_HYDRATE: begin
                    if (v) begin
                        if (rec_unack[s] != 0 || rec_qmask[s] != 0 || rec_fmask[s] != 0) begin
                            ok = (rev == rec_acked[s]);
                        end else if (rev >= rec_acked[s]) begin
                            load_record(s, rev);
                            ok = 1;
                        end
                    end else if (used_cnt < cap_cfg) begin
                        rec_valid[s] = 1'b1;
                        used_cnt++;
                        load_record(s, rev);
                        rec_qrev[s] = '0;
                        rec_frev[s] = '0;
                        rec_dirty[s] = '0;
                        rec_unack[s] = '0;
                        rec_qmask[s] = '0;
                        rec_fmask[s] = '0;
                        rec_ovf[s] = 1'b0;
                        ok = 1;
                    end
                end
                crt_pkg::ACT_MARK: begin
                    if (v && mask_legal(m) && !rec_ovf[s]) begin
                        if (rec_cur[s] == 32'hFFFF_FFFF) begin
                            rec_ovf[s] = 1'b1;
                        end else begin
                            rec_cur[s]++;
                            rec_dirty[s] |= m;
                            rec_unack[s] |= m;
                            for (int i = 0; i < NCOMP; i++)
                                if (m[i]) rec_comp_rev[s][i] = rec_cur[s];
                            ok = 1;
                        end
                    end
                end
                crt_pkg::ACT_QUEUE: begin
                    if (v && rec_unack[s] != 0) begin
                        rec_qrev[s] = rec_cur[s];
                        rec_qmask[s] = rec_unack[s];
                        rec_dirty[s] = '0;
                        ok = 1;
                    end
                end
                crt_pkg::ACT_BEGIN: begin
                    if (v && rec_fmask[s] == 0 && rev == rec_qrev[s] && m == rec_qmask[s]
                        && mask_legal(m)) begin
                        rec_frev[s] = rev;
                        rec_fmask[s] = m;
                        rec_qrev[s] = '0;
                        rec_qmask[s] = '0;
                        ok = 1;
                    end
                end
                crt_pkg::ACT_ACK: begin
                    if (v && rev == rec_frev[s] && m == rec_fmask[s] && mask_legal(m)) begin
                        retire_components(s, rev, m);
                        if (rev > rec_acked[s]) rec_acked[s] = rev;
                        rec_frev[s] = '0;
                        rec_fmask[s] = '0;
                        ok = 1;
                    end
                end
                crt_pkg::ACT_ACK_DUR: begin
                    if (v && mask_legal(m) && rev >= rec_acked[s] && rev <= rec_cur[s]) begin
                        prior_unack = rec_unack[s];
                        retire_components(s, rev, m);
                        rec_fmask[s] &= ~(prior_unack & ~rec_unack[s]);
                        if (rec_qmask[s] == 0) rec_qrev[s] = '0;
                        if (rec_fmask[s] == 0) rec_frev[s] = '0;
                        if (rev > rec_acked[s]) rec_acked[s] = rev;
                        ok = 1;
                    end
                end
                crt_pkg::ACT_FAIL: begin
                    if (v && rev == rec_frev[s] && m == rec_fmask[s] && mask_legal(m)) begin
                        rec_frev[s] = '0;
                        rec_fmask[s] = '0;
                        rec_qrev[s] = rec_cur[s];
                        rec_qmask[s] = rec_unack[s];
                        ok = 1;
                    end
                end
                crt_pkg::ACT_SNAPSHOT: ok = v;
                crt_pkg::ACT_FORGET: begin
                    if (v) begin
                        rec_valid[s] = 1'b0;
                        used_cnt--;
                        ok = 1;
                    end
                end
                default: ;
            endcase
        end
        v = (id != 0) && rec_valid[s];
        if (v && rec_unack[s] != 0) unacked_cnt++;
        r = '0;
        r.ok = ok;
        if (v) begin
            r.cur_rev = rec_cur[s];
            r.acked_rev = rec_acked[s];
            r.queued_rev = rec_qrev[s];
            r.flight_rev = rec_frev[s];
            r.dirty_mask = rec_dirty[s];
            r.unacked_mask = rec_unack[s];
            r.queued_mask = rec_qmask[s];
            r.flight_mask = rec_fmask[s];
            r.overflow_flag = rec_ovf[s];
        end
        r.entries_used = used_cnt;
        r.entries_unacked = unacked_cnt;
        pending_results.push_back(r);
    endtask

    // send one request, then predict its result once accepted
    task automatic send_request(logic [3:0] act, logic [9:0] id, logic [31:0] rev,
                                logic [13:0] m);
        int gap;
        gap = tx_nogap ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, m, rev, id, act};
        do @(posedge aclk); while (!s_axis_tready);
        apply_action(act, id, rev, m);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == crt_pkg::CFG_IDX_MASK) comp_mask_cfg = val[13:0];
        else cap_cfg = val[10:0];
        @(posedge aclk);
    endtask

    task automatic drain();
        @(posedge aclk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (6) @(posedge aclk);
    endtask

    // random request biased toward well-formed lifecycles on a small id pool
    task automatic random_request(int pool);
        logic [3:0]  act;
        logic [9:0]  id;
        logic [31:0] rev;
        logic [13:0] m;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) id = 0;
        else if (pick < 7) id = 10'($urandom_range(1, 1023));
        else id = 10'($urandom_range(1, pool));
        act = $urandom_range(0, 99) < 4 ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
        rev = $urandom;
        m = 14'($urandom);
        if ($urandom_range(0, 99) < 80) begin
            case (act)
                crt_pkg::ACT_HYDRATE: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 2) rev = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    else if (pick < 6) rev = rec_acked[id] + $urandom_range(0, 2);
                    else rev = $urandom_range(0, 1000);
                end
                crt_pkg::ACT_MARK: m = 14'($urandom) & comp_mask_cfg;
                crt_pkg::ACT_BEGIN: begin
                    rev = rec_qrev[id];
                    m = rec_qmask[id];
                end
                crt_pkg::ACT_ACK, crt_pkg::ACT_FAIL: begin
                    rev = rec_frev[id];
                    m = rec_fmask[id];
                end
                crt_pkg::ACT_ACK_DUR: begin
                    rev = rec_acked[id] + $urandom_range(0, 3);
                    m = 14'($urandom) & comp_mask_cfg;
                end
                default: ;
            endcase
        end
        send_request(act, id, rev, m);
    endtask

    // ready side with random stalls and an optional long hold-off
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            int n;
            if (rx_hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge aclk);
                rx_hold_len = 0;
            end
            n = rx_nogap ? 0 : $urandom_range(0, 13);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid && rx_hold_len == 0);
        end
    end

    // result checker
    always @(posedge aclk) begin
        record_res_t got;
        record_res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_TO) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(crt_pkg::ACT_HYDRATE, 10'd0, 32'd7, 14'h1);
        send_request(crt_pkg::ACT_HYDRATE, 10'd1, 32'd5, 14'h0);
        send_request(crt_pkg::ACT_MARK, 10'd1, 32'd0, 14'h0);
        send_request(crt_pkg::ACT_MARK, 10'd1, 32'd0, 14'h3);
        send_request(crt_pkg::ACT_HYDRATE, 10'd1, 32'd5, 14'h0);
        send_request(crt_pkg::ACT_QUEUE, 10'd1, 32'd0, 14'h0);
        send_request(crt_pkg::ACT_BEGIN, 10'd1, rec_qrev[1], rec_qmask[1]);
        send_request(crt_pkg::ACT_ACK, 10'd1, rec_frev[1], rec_fmask[1]);
        send_request(crt_pkg::ACT_MARK, 10'd1, 32'hFFFF_FFFF, 14'h3FFF);
        send_request(crt_pkg::ACT_QUEUE, 10'd1, 32'd0, 14'h0);
        send_request(crt_pkg::ACT_BEGIN, 10'd1, rec_qrev[1], rec_qmask[1]);
        send_request(crt_pkg::ACT_FAIL, 10'd1, rec_frev[1], rec_fmask[1]);
        send_request(crt_pkg::ACT_BEGIN, 10'd1, rec_qrev[1], rec_qmask[1]);
        send_request(crt_pkg::ACT_ACK_DUR, 10'd1, rec_cur[1], 14'h2000);
        send_request(crt_pkg::ACT_SNAPSHOT, 10'd1, 32'd0, 14'h0);
        send_request(4'hF, 10'd1, 32'hFFFF_FFFF, 14'h3FFF);
        send_request(crt_pkg::ACT_HYDRATE, 10'd1023, 32'hFFFF_FFFF, 14'h0);
        send_request(crt_pkg::ACT_MARK, 10'd1023, 32'd0, 14'h1);
        send_request(crt_pkg::ACT_MARK, 10'd1023, 32'd0, 14'h1);
        send_request(crt_pkg::ACT_FORGET, 10'd1023, 32'd0, 14'h0);
        send_request(crt_pkg::ACT_FORGET, 10'd1023, 32'd0, 14'h0);
        send_request(crt_pkg::ACT_SNAPSHOT, 10'd1023, 32'd0, 14'h0);
        send_request(crt_pkg::ACT_SNAPSHOT, 10'd0, 32'd0, 14'h0);
        drain();
    endtask

    task automatic test_random(int count, int pool);
        for (int i = 0; i < count; i++) begin
            // alternating stretches without idling
            tx_nogap = (i % 100) >= 80;
            rx_nogap = (i % 100) >= 70 && (i % 100) < 90;
            random_request(pool);
        end
        tx_nogap = 0;
        rx_nogap = 0;
        drain();
    endtask

    task automatic test_backpressure();
        rx_hold_len = 300;
        tx_nogap = 1;
        for (int i = 0; i < 40; i++) random_request(12);
        tx_nogap = 0;
        // sender waits until every result has come back
        wait (pending_results.size() == 0);
        for (int i = 0; i < 20; i++) random_request(12);
        drain();
    endtask

    task automatic test_config_sweep();
        write_reg(crt_pkg::CFG_IDX_CAP, 16'd0);
        write_reg(crt_pkg::CFG_IDX_MASK, 16'd1);
        test_random(60, 20);
        write_reg(crt_pkg::CFG_IDX_CAP, 16'd4);
        write_reg(crt_pkg::CFG_IDX_MASK, 16'h2A5A);
        test_random(250, 12);
        write_reg(crt_pkg::CFG_IDX_MASK, 16'h3FFF);
        write_reg(crt_pkg::CFG_IDX_CAP, 16'd1024);
        test_random(400, 10);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(300, 8);
        test_backpressure();
        test_config_sweep();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* checkpoint_revision_tracker_top.f */
hdl/crt_pkg.sv
hdl/crt_store.sv
hdl/checkpoint_revision_tracker_top.sv
verif/tb.sv
